// File: sv/rar_pkg.sv
// ----------------------------------------------------------------------------
// rar_pkg
// Shared types and constants for the fraction arithmetic and reduction block.
// ----------------------------------------------------------------------------
package rar_pkg;

    localparam int OW = 16;
    localparam int MW = 2 * OW + 1;
    localparam int NUM_W = 33;
    localparam int DEN_W = 31;
    localparam int CW = $clog2(MW + 1);

    typedef enum logic [1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } act_t;

    typedef struct packed {
        logic          err;
        logic          neg;
        logic [MW-1:0] num;
        logic [MW-1:0] den;
    } job_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_GCD,
        BK_DIVN,
        BK_DIVD,
        BK_DONE
    } bk_state_t;

endpackage

// File: sv/rar_front.sv
// ----------------------------------------------------------------------------
// rar_front
// Accepts an item, forms the raw numerator and denominator in two stages.
// ----------------------------------------------------------------------------
module rar_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          action,
    input  logic [rar_pkg::OW-1:0] first_num,
    input  logic [rar_pkg::OW-1:0] first_den,
    input  logic [rar_pkg::OW-1:0] second_num,
    input  logic [rar_pkg::OW-1:0] second_den,
    output logic                job_valid,
    input  logic                job_ready,
    output rar_pkg::job_t       job
);

    localparam int OW = rar_pkg::OW;
    localparam int MW = rar_pkg::MW;

    logic             s1_valid_reg;
    logic             s2_valid_reg;
    logic [1:0]       act_reg;
    logic             bad_reg;
    logic [OW-1:0]    ma_reg, mb_reg, mc_reg, md_reg;
    logic             na_reg, nb_reg, nc_reg, nd_reg;
    logic [2*OW-1:0]  p1_reg, p2_reg, p3_reg;
    logic             pn1_reg, pn2_reg, pn3_reg;
    logic [1:0]       act2_reg;
    logic             bad2_reg;
    logic [OW-1:0]    m1, m2, m3, m4;
    logic [OW-1:0]    x1, x2, x3, x4;
    logic [2*OW-1:0]  q1, q2, q3;
    logic             s1_adv;
    logic             s2_free;
    logic [MW-1:0]    e1, e2, sum;
    logic             sn;

    function automatic logic [OW-1:0] mag(input logic [OW-1:0] v);
        mag = v[OW-1] ? (~v + 1'b1) : v;
    endfunction

    assign m1 = mag(first_num);
    assign m2 = mag(first_den);
    assign m3 = mag(second_num);
    assign m4 = mag(second_den);

    assign s2_free = !s2_valid_reg || job_ready;
    assign s1_adv  = s1_valid_reg && s2_free;
    assign in_ready = !s1_valid_reg || s2_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                s1_valid_reg <= in_valid;
            if (s2_free)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_comb
    begin
        x1 = ma_reg;
        x2 = md_reg;
        x3 = mc_reg;
        x4 = mb_reg;
        unique case (rar_pkg::act_t'(act_reg))
            rar_pkg::ACT_ADD, rar_pkg::ACT_SUB:
            begin
                x1 = ma_reg; x2 = md_reg; x3 = mc_reg; x4 = mb_reg;
            end
            rar_pkg::ACT_MUL:
            begin
                x1 = ma_reg; x2 = mc_reg; x3 = mb_reg; x4 = md_reg;
            end
            rar_pkg::ACT_DIV:
            begin
                x1 = ma_reg; x2 = md_reg; x3 = mb_reg; x4 = mc_reg;
            end
            default:
            begin
                x1 = ma_reg;
            end
        endcase
    end

    assign q1 = x1 * x2;
    assign q2 = x3 * x4;
    assign q3 = mb_reg * md_reg;

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            act_reg <= action;
            ma_reg <= m1; mb_reg <= m2; mc_reg <= m3; md_reg <= m4;
            na_reg <= first_num[OW-1]; nb_reg <= first_den[OW-1];
            nc_reg <= second_num[OW-1]; nd_reg <= second_den[OW-1];
            bad_reg <= (m2 == '0) || (m4 == '0) ||
                       ((action == rar_pkg::ACT_DIV) && (m3 == '0));
        end
        if (s1_adv)
        begin
            act2_reg <= act_reg;
            bad2_reg <= bad_reg;
            p1_reg <= q1;
            p2_reg <= q2;
            p3_reg <= q3;
            pn1_reg <= na_reg ^ ((act_reg == rar_pkg::ACT_MUL) ? nc_reg : nd_reg);
            pn2_reg <= (act_reg == rar_pkg::ACT_MUL) ? (nb_reg ^ nd_reg) :
                       (act_reg == rar_pkg::ACT_DIV) ? (nb_reg ^ nc_reg) :
                       (nc_reg ^ nb_reg ^ (act_reg == rar_pkg::ACT_SUB));
            pn3_reg <= nb_reg ^ nd_reg;
        end
    end

    assign e1 = {1'b0, p1_reg};
    assign e2 = {1'b0, p2_reg};

    always_comb
    begin
        sum = '0;
        sn  = 1'b0;
        if (act2_reg == rar_pkg::ACT_ADD || act2_reg == rar_pkg::ACT_SUB)
        begin
            if (pn1_reg == pn2_reg)
            begin
                sum = e1 + e2;
                sn  = pn1_reg;
            end
            else if (e1 >= e2)
            begin
                sum = e1 - e2;
                sn  = pn1_reg;
            end
            else
            begin
                sum = e2 - e1;
                sn  = pn2_reg;
            end
        end
    end

    assign job_valid = s2_valid_reg;

    always_comb
    begin
        job.err = bad2_reg;
        if (act2_reg == rar_pkg::ACT_ADD || act2_reg == rar_pkg::ACT_SUB)
        begin
            job.num = sum;
            job.den = {1'b0, p3_reg};
            job.neg = sn ^ pn3_reg;
        end
        else
        begin
            job.num = e1;
            job.den = e2;
            job.neg = pn1_reg ^ pn2_reg;
        end
    end

endmodule

// File: sv/rar_queue.sv
// ----------------------------------------------------------------------------
// rar_queue
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
module rar_queue
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_valid,
    output logic          wr_ready,
    input  rar_pkg::job_t wr_data,
    output logic          rd_valid,
    input  logic          rd_ready,
    output rar_pkg::job_t rd_data
);

    rar_pkg::job_t mem_reg [2];
    logic          wp_reg, rp_reg;
    logic [1:0]    cnt_reg;
    logic          wr, rd;

    assign wr_ready = cnt_reg != 2'd2;
    assign rd_valid = cnt_reg != 2'd0;
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;
    assign rd_data = mem_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (wr)
                wp_reg <= !wp_reg;
            if (rd)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, wr} - {1'b0, rd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
            mem_reg[wp_reg] <= wr_data;
    end

endmodule

// File: sv/rar_back.sv
// ----------------------------------------------------------------------------
// rar_back
// Runs Euclid's loop and the two final divisions on one shared bit-serial
// divider, then holds the result until it is taken.
// ----------------------------------------------------------------------------
module rar_back
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     job_valid,
    output logic                     job_ready,
    input  rar_pkg::job_t            job,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [rar_pkg::NUM_W-1:0] res_num,
    output logic [rar_pkg::DEN_W-1:0] res_den,
    output logic                     err
);

    localparam int MW = rar_pkg::MW;
    localparam int CW = rar_pkg::CW;
    localparam int NUM_W_T = rar_pkg::NUM_W;

    rar_pkg::bk_state_t state_reg, state_next;
    logic [MW-1:0] num_reg, den_reg, a_reg, b_reg;
    logic [MW-1:0] dq_reg, dr_reg, dd_reg;
    logic [CW-1:0] cnt_reg;
    logic          busy_reg;
    logic          neg_reg, err_reg;
    logic [NUM_W_T-1:0] rn_reg;
    logic [rar_pkg::DEN_W-1:0] rd_reg;
    logic [MW:0]   trial;
    logic [MW-1:0] rem_sh;
    logic          dstart;
    logic [MW-1:0] dnum, dden;
    logic          ddone;
    logic          take;

    assign rem_sh = {dr_reg[MW-2:0], dq_reg[MW-1]};
    assign trial  = {1'b0, rem_sh} - {1'b0, dd_reg};
    assign ddone  = busy_reg && (cnt_reg == CW'(1));
    assign take   = job_valid && job_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            rar_pkg::BK_IDLE:
                if (take)
                    state_next = job.err ? rar_pkg::BK_DONE : rar_pkg::BK_GCD;
            rar_pkg::BK_GCD:
                if (!busy_reg && b_reg == '0)
                    state_next = rar_pkg::BK_DIVN;
            rar_pkg::BK_DIVN:
                if (ddone)
                    state_next = rar_pkg::BK_DIVD;
            rar_pkg::BK_DIVD:
                if (ddone)
                    state_next = rar_pkg::BK_DONE;
            rar_pkg::BK_DONE:
                if (out_ready)
                    state_next = rar_pkg::BK_IDLE;
            default:
                state_next = rar_pkg::BK_IDLE;
        endcase
    end

    always_comb
    begin
        job_ready = 1'b0;
        out_valid = 1'b0;
        dstart    = 1'b0;
        dnum      = a_reg;
        dden      = b_reg;
        unique case (state_reg)
            rar_pkg::BK_IDLE:
                job_ready = 1'b1;
            rar_pkg::BK_GCD:
                dstart = !busy_reg && b_reg != '0;
            rar_pkg::BK_DIVN:
            begin
                dstart = !busy_reg;
                dnum   = num_reg;
                dden   = a_reg;
            end
            rar_pkg::BK_DIVD:
            begin
                dstart = !busy_reg;
                dnum   = den_reg;
                dden   = a_reg;
            end
            rar_pkg::BK_DONE:
                out_valid = 1'b1;
            default:
                job_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rar_pkg::BK_IDLE;
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (dstart)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(MW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (ddone)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            num_reg <= job.num;
            den_reg <= job.den;
            a_reg   <= job.num;
            b_reg   <= job.den;
            neg_reg <= job.neg && job.num != '0;
            err_reg <= job.err;
            rn_reg  <= '0;
            rd_reg  <= '0;
        end
        if (dstart)
        begin
            dq_reg <= dnum;
            dr_reg <= '0;
            dd_reg <= dden;
        end
        else if (busy_reg)
        begin
            dq_reg <= {dq_reg[MW-2:0], !trial[MW]};
            dr_reg <= trial[MW] ? rem_sh : trial[MW-1:0];
        end
        if (ddone)
        begin
            unique case (state_reg)
                rar_pkg::BK_GCD:
                begin
                    a_reg <= b_reg;
                    b_reg <= trial[MW] ? rem_sh : trial[MW-1:0];
                end
                rar_pkg::BK_DIVN:
                    rn_reg <= neg_reg ? (NUM_W_T'(0) - NUM_W_T'({dq_reg[MW-2:0], !trial[MW]}))
                                      : NUM_W_T'({dq_reg[MW-2:0], !trial[MW]});
                rar_pkg::BK_DIVD:
                    rd_reg <= rar_pkg::DEN_W'({dq_reg[MW-2:0], !trial[MW]});
                default:
                    rd_reg <= rd_reg;
            endcase
        end
    end

    assign res_num = rn_reg;
    assign res_den = rd_reg;
    assign err     = err_reg;

endmodule

// File: sv/rational_arith_reduce.sv
// ----------------------------------------------------------------------------
// rational_arith_reduce
// Adds, subtracts, multiplies or divides two signed fractions and reduces
// the result to lowest terms with a positive denominator.
// ----------------------------------------------------------------------------
// Channel  Direction  Contents
// s_axis   in         tdata: action, first_num, first_den, second_num, second_den
// m_axis   out        tdata: res_num, res_den; tuser: err
//
// Each Euclid step is one bit-serial division that loads its operands and then
// shifts out the quotient; the two final divisions run on the same divider, so
// an item's time grows with its number of Euclid steps. Error items skip the
// divisions and go straight to the result.
// The front multiplies while the back reduces; a two-entry queue decouples.
// Reset clears all control state; the back holds its result under stall.
// ----------------------------------------------------------------------------
module rational_arith_reduce
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // action, first_num, first_den, second_num, second_den
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // res_num, res_den
    output logic        m_axis_tuser   // err
);

    logic          f_valid, f_ready, q_valid, q_ready;
    rar_pkg::job_t f_job, q_job;
    logic [rar_pkg::NUM_W-1:0] res_num;
    logic [rar_pkg::DEN_W-1:0] res_den;

    rar_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .action     (s_axis_tdata[1:0]),
        .first_num  (s_axis_tdata[17:2]),
        .first_den  (s_axis_tdata[33:18]),
        .second_num (s_axis_tdata[49:34]),
        .second_den (s_axis_tdata[65:50]),
        .job_valid  (f_valid),
        .job_ready  (f_ready),
        .job        (f_job)
    );

    rar_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (f_valid),
        .wr_ready (f_ready),
        .wr_data  (f_job),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_data  (q_job)
    );

    rar_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (q_valid),
        .job_ready (q_ready),
        .job       (q_job),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .res_num   (res_num),
        .res_den   (res_den),
        .err       (m_axis_tuser)
    );

    assign m_axis_tdata = {res_den, res_num};

endmodule

// File: sv/rar_checker.sv
// ----------------------------------------------------------------------------
// rar_checker
// Port-level checks on the fraction reduction block.
// ----------------------------------------------------------------------------
module rar_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("error result not zero");

    a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[63:33] != 31'd0)
        else $error("zero denominator without error");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");

endmodule

bind rational_arith_reduce rar_checker u_rar_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the fraction arithmetic and reduction block. Random
// and corner fractions are streamed in, a local model forms each reduced
// result, and every output transfer is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [32:0] num;
        logic [30:0] den;
        logic        err;
    } frac_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic [71:0] pending_ops[$];
    frac_res_t   expected_fracs[$];
    int          mismatches;
    int          checked;
    int          err_seen;
    bit          calm;
    bit          sender_hold;
    bit          in_taken = 1'b0;

    rational_arith_reduce i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
        logic [63:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic frac_res_t reduce_fraction(logic [71:0] op);
        rar_pkg::act_t      act;
        longint signed      n1;
        longint signed      d1;
        longint signed      n2;
        longint signed      d2;
        longint signed      num;
        longint signed      den;
        logic [63:0]        nm;
        logic [63:0]        dm;
        logic [63:0]        g;
        logic               neg;
        frac_res_t          r;
        act = rar_pkg::act_t'(op[1:0]);
        n1 = longint'($signed(op[17:2]));
        d1 = longint'($signed(op[33:18]));
        n2 = longint'($signed(op[49:34]));
        d2 = longint'($signed(op[65:50]));
        r = '0;
        if (d1 == 0 || d2 == 0 || (act == rar_pkg::ACT_DIV && n2 == 0))
        begin
            r.err = 1'b1;
            return r;
        end
        case (act)
            rar_pkg::ACT_ADD:
            begin
                num = n1 * d2 + n2 * d1;
                den = d1 * d2;
            end
            rar_pkg::ACT_SUB:
            begin
                num = n1 * d2 - n2 * d1;
                den = d1 * d2;
            end
            rar_pkg::ACT_MUL:
            begin
                num = n1 * n2;
                den = d1 * d2;
            end
            default:
            begin
                num = n1 * d2;
                den = d1 * n2;
            end
        endcase
        nm = (num < 0) ? -num : num;
        dm = (den < 0) ? -den : den;
        g = gcd64(nm, dm);
        nm = nm / g;
        dm = dm / g;
        neg = (nm != 0) && ((num < 0) != (den < 0));
        r.num = neg ? 33'(-nm) : 33'(nm);
        r.den = dm[30:0];
        return r;
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 8)) - 4);
            3, 4: return 16'(int'($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_op(rar_pkg::act_t act, logic [15:0] n1, logic [15:0] d1,
                            logic [15:0] n2, logic [15:0] d2);
        pending_ops.push_back({6'b0, d2, n2, d1, n1, act});
    endtask

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n = 1'b1;
    end

    initial
    begin
        #40ms;
        $display("end of test: mismatches");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            expected_fracs.push_back(reduce_fraction(s_axis_tdata));
            void'(pending_ops.pop_front());
            in_taken = 1'b1;
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_taken = 1'b0;
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else if (!s_axis_tvalid || in_taken)
        begin
            in_taken = 1'b0;
            if (pending_ops.size() != 0 && !sender_hold
                && (calm || $urandom_range(0, 99) >= 6))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_ops[0];
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= calm || $urandom_range(0, 99) >= 6;
    end

    always @(posedge clk)
    begin
        frac_res_t got;
        frac_res_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.num = m_axis_tdata[32:0];
            got.den = m_axis_tdata[63:33];
            got.err = m_axis_tuser;
            if (expected_fracs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer num=%h den=%h err=%b",
                             got.num, got.den, got.err);
            end
            else
            begin
                want = expected_fracs.pop_front();
                checked++;
                if (got.err)
                    err_seen++;
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result %0d: expected num=%h den=%h err=%b, ",
                                  "got num=%h den=%h err=%b"},
                                 checked, want.num, want.den, want.err,
                                 got.num, got.den, got.err);
                end
            end
        end
    end

    initial
    begin
        int wait_cycles;
        mismatches  = 0;
        checked     = 0;
        err_seen    = 0;
        calm        = 1'b0;
        sender_hold = 1'b0;

        queue_op(rar_pkg::ACT_ADD, 16'h8000, 16'd1, 16'h8000, 16'd1);
        queue_op(rar_pkg::ACT_SUB, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        queue_op(rar_pkg::ACT_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h7fff);
        queue_op(rar_pkg::ACT_DIV, 16'h7fff, 16'h8000, 16'h8000, 16'h8000);
        queue_op(rar_pkg::ACT_ADD, 16'd1, 16'd0, 16'd1, 16'd2);
        queue_op(rar_pkg::ACT_MUL, 16'd3, 16'd4, 16'd5, 16'd0);
        queue_op(rar_pkg::ACT_DIV, 16'd3, 16'd4, 16'd0, 16'd7);
        queue_op(rar_pkg::ACT_SUB, 16'd3, 16'd4, 16'd3, 16'd4);
        queue_op(rar_pkg::ACT_MUL, 16'd0, 16'hffff, 16'd5, 16'd3);
        queue_op(rar_pkg::ACT_ADD, 16'd1, 16'hfffe, 16'd1, 16'hfffe);
        queue_op(rar_pkg::ACT_DIV, 16'hfffd, 16'd4, 16'd6, 16'hfff8);
        queue_op(rar_pkg::ACT_ADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        queue_op(rar_pkg::ACT_MUL, 16'd6, 16'd9, 16'd12, 16'd8);
        queue_op(rar_pkg::ACT_DIV, 16'd0, 16'd0, 16'd0, 16'd0);
        queue_op(rar_pkg::ACT_SUB, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        queue_op(rar_pkg::ACT_ADD, 16'h5555, 16'haaaa, 16'haaaa, 16'h5555);
        for (int i = 0; i < 1400; i++)
            queue_op(rar_pkg::act_t'($urandom_range(0, 3)), pick_operand(),
                     ($urandom_range(0, 29) == 0) ? 16'd0 : pick_operand(),
                     pick_operand(),
                     ($urandom_range(0, 29) == 0) ? 16'd0 : pick_operand());

        @(posedge rst_n);
        while (pending_ops.size() > 900)
            @(posedge clk);
        sender_hold = 1'b1;
        while (expected_fracs.size() != 0 || s_axis_tvalid)
            @(posedge clk);
        sender_hold = 1'b0;
        calm = 1'b1;
        while (pending_ops.size() > 650)
            @(posedge clk);
        calm = 1'b0;
        while (pending_ops.size() != 0)
            @(posedge clk);
        while (expected_fracs.size() != 0)
            @(posedge clk);
        wait_cycles = 200;
        repeat (wait_cycles) @(posedge clk);

        $display("checked %0d fraction results (%0d with error flag) over all four operations,",
                 checked, err_seen);
        $display("including extreme operands, zero denominators and zero divisors.");
        if (mismatches == 0 && expected_fracs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule

// File: filelist.f
sv/rar_pkg.sv
sv/rar_front.sv
sv/rar_queue.sv
sv/rar_back.sv
sv/rational_arith_reduce.sv
sv/rar_checker.sv
test/tb_top.sv
